>>> rtl/oaht_pkg.sv
// Package: shared constants, codes and types of the open-addressing hash table.
`timescale 1ns / 1ps
package oaht_pkg;

  // Table geometry
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  // floor(log2(CAPACITY)): number of hash bits taken from the product
  localparam int HASH_L   = $clog2(CAPACITY + 1) - 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Golden-ratio fraction (sqrt(5)-1)/2 in unsigned 0.32 fixed point
  localparam logic [31:0] GOLDEN_Q32 = 32'd2654435769;

  localparam int KEY_W = 31;
  localparam int VAL_W = 31;

  // Operation codes
  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_SET    = 2'd2;
  localparam logic [1:0] FN_QUERY  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;

  // Slot marks; the unused fourth code behaves as a tombstone
  localparam logic [1:0] MK_EMPTY = 2'd0;
  localparam logic [1:0] MK_LIVE  = 2'd1;
  localparam logic [1:0] MK_TOMB  = 2'd2;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] center;
    logic [VAL_W-1:0] load;
  } oaht_rec_t;

  // Access request from the controller to the slot store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             mark_we;
    logic [1:0]       mark_wdata;
    logic             rec_we;
    oaht_rec_t        rec_wdata;
  } oaht_req_t;

  // Read data and status returned by the slot store
  typedef struct packed {
    logic [1:0] mark;
    oaht_rec_t  rec;
    logic       clr_busy;
  } oaht_rsp_t;

endpackage

>>> rtl/oaht_hash.sv
// Fibonacci multiplicative hash unit: registered home slot of a key.
`timescale 1ns / 1ps
module oaht_hash (
  input  logic                      clk,
  input  logic                      load,
  input  logic [31:0]               key,
  output logic [oaht_pkg::IDX_W-1:0] home
);
  import oaht_pkg::*;

  logic [31:0] prod;

  // Capture the low word of key * golden fraction
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= key * GOLDEN_Q32;
    end
  end

  // Take the top hash bits as the home slot
  assign home = IDX_W'(prod[31 -: HASH_L]);

endmodule

>>> rtl/oaht_store.sv
// Slot store: mark memory with reset clearing pass, and record memory.
`timescale 1ns / 1ps
module oaht_store (
  input  logic                clk,
  input  logic                rst,
  input  oaht_pkg::oaht_req_t req,
  output oaht_pkg::oaht_rsp_t rsp
);
  import oaht_pkg::*;

  logic [1:0]       mark_mem [CAPACITY];
  oaht_rec_t        rec_mem  [CAPACITY];
  logic [1:0]       rd_mark;
  oaht_rec_t        rd_rec;
  logic             clr_busy;
  logic [IDX_W-1:0] clr_addr;

  // Sweep the mark memory to empty after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == IDX_W'(CAPACITY - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Mark memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mark_mem[clr_addr] <= MK_EMPTY;
    end else if (req.mark_we) begin
      mark_mem[req.wr_addr] <= req.mark_wdata;
    end
    if (req.rd_en) begin
      rd_mark <= mark_mem[req.rd_addr];
    end
  end

  // Record memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (req.rec_we) begin
      rec_mem[req.wr_addr] <= req.rec_wdata;
    end
    if (req.rd_en) begin
      rd_rec <= rec_mem[req.rd_addr];
    end
  end

  assign rsp.mark     = rd_mark;
  assign rsp.rec      = rd_rec;
  assign rsp.clr_busy = clr_busy;

endmodule

>>> rtl/open_addressing_hash_table_core.sv
// Top level: probe sequencer and result register of the hash table.
//
// Usage: one input channel (in_valid / in_stall) carries func, key,
// center_id and load_value; one output channel (out_valid / out_stall)
// returns status, found_center and found_load, one result per item, in
// order. A transfer happens when valid is high and stall is low.
// After reset the block runs a clearing pass over all CAPACITY slot
// marks; in_stall stays high during it.
// One item is worked at a time. An invalid key, or an invalid load on a
// set, skips the probe and goes straight to the result stage; otherwise
// the block probes slots, one per mark/record memory read, at most
// CAPACITY of them (one or a few at moderate load), and then resolves
// the item. The next item is accepted once the current result has
// moved into the output register, even while that register still waits
// for the receiver; when the receiver stalls, the next finished result
// waits in its own stage and the block takes no further item until the
// output register frees up.
`timescale 1ns / 1ps
module open_addressing_hash_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  input  logic [30:0] center_id,
  input  logic [31:0] load_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [30:0] found_center,
  output logic [30:0] found_load
);
  import oaht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_FINISH,
    S_RESP
  } state_t;

  state_t           state;
  oaht_req_t        req;
  oaht_rsp_t        rsp;
  logic [IDX_W-1:0] home;
  logic             in_xfer;
  logic             key_ok;
  logic             load_ok;

  logic [1:0]       func_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] center_r;
  logic [VAL_W-1:0] load_r;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_inc;
  logic [IDX_W-1:0] cnt;
  logic             found;
  logic [IDX_W-1:0] hit_pos;
  oaht_rec_t        hit_rec;
  logic             free_ok;
  logic [IDX_W-1:0] free_pos;
  logic [CNT_W-1:0] live_count;
  logic             hit_now;
  logic             add_ok;
  logic             out_load;

  logic [1:0]       res_status;
  logic [VAL_W-1:0] res_center;
  logic [VAL_W-1:0] res_load;

  oaht_hash u_hash (
    .clk  (clk),
    .load (in_xfer),
    .key  (key),
    .home (home)
  );

  oaht_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_stall = (state != S_IDLE) || rsp.clr_busy;
  assign in_xfer  = in_valid && !in_stall;
  assign key_ok   = !key[31] && (key != 32'd0);
  assign load_ok  = !load_value[31] && (load_value != 32'd0);
  assign pos_inc  = (pos == IDX_W'(CAPACITY - 1)) ? '0 : pos + 1'b1;
  assign hit_now  = (rsp.mark == MK_LIVE) && (rsp.rec.key == key_r);
  assign add_ok   = !found && free_ok && (live_count < CNT_W'(CAPACITY));
  assign out_load = (state == S_RESP) && (!out_valid || !out_stall);

  // Drive memory reads along the probe path and the final write-back
  always_comb begin
    req            = '0;
    req.rd_addr    = pos_inc;
    req.wr_addr    = found ? hit_pos : free_pos;
    req.rec_wdata  = hit_rec;
    req.mark_wdata = MK_LIVE;
    unique case (state)
      S_START: begin
        req.rd_en   = 1'b1;
        req.rd_addr = home;
      end
      S_CHECK: begin
        req.rd_en = !hit_now && (rsp.mark != MK_EMPTY) && (cnt != IDX_W'(CAPACITY - 1));
      end
      S_FINISH: begin
        unique case (func_r)
          FN_ADD: begin
            if (add_ok) begin
              req.mark_we        = 1'b1;
              req.mark_wdata     = MK_LIVE;
              req.rec_we         = 1'b1;
              req.rec_wdata.key  = key_r;
              req.rec_wdata.center = center_r;
              req.rec_wdata.load = '0;
            end
          end
          FN_DELETE: begin
            req.mark_we    = found;
            req.mark_wdata = MK_TOMB;
          end
          FN_SET: begin
            req.rec_we         = found;
            req.rec_wdata.load = load_r;
          end
          FN_QUERY: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequence one item: accept, probe, resolve, stage, transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      live_count <= '0;
      found      <= 1'b0;
      free_ok    <= 1'b0;
    end else begin
      // Load a staged result or drop a transferred one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            func_r   <= func;
            key_r    <= key[30:0];
            center_r <= center_id;
            load_r   <= load_value[30:0];
            found    <= 1'b0;
            free_ok  <= 1'b0;
            if (!key_ok || ((func == FN_SET) && !load_ok)) begin
              res_status <= ST_INVALID;
              res_center <= '0;
              res_load   <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          pos   <= home;
          cnt   <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (hit_now) begin
            found   <= 1'b1;
            hit_pos <= pos;
            hit_rec <= rsp.rec;
            state   <= S_FINISH;
          end else begin
            if ((rsp.mark != MK_LIVE) && !free_ok) begin
              free_ok  <= 1'b1;
              free_pos <= pos;
            end
            if ((rsp.mark == MK_EMPTY) || (cnt == IDX_W'(CAPACITY - 1))) begin
              state <= S_FINISH;
            end else begin
              pos <= pos_inc;
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_FINISH: begin
          res_center <= (found && (func_r == FN_QUERY)) ? hit_rec.center : '0;
          res_load   <= (found && (func_r == FN_QUERY)) ? hit_rec.load : '0;
          if (func_r == FN_ADD) begin
            res_status <= add_ok ? ST_OK : ST_FAIL;
          end else begin
            res_status <= found ? ST_OK : ST_FAIL;
          end
          unique case (func_r)
            FN_ADD: begin
              if (add_ok) begin
                live_count <= live_count + 1'b1;
              end
            end
            FN_DELETE: begin
              if (found && (live_count != '0)) begin
                live_count <= live_count - 1'b1;
              end
            end
            FN_SET: begin
            end
            FN_QUERY: begin
            end
            default: begin
            end
          endcase
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            status       <= res_status;
            found_center <= res_center;
            found_load   <= res_load;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
